@@ design/vcli_pkg.sv @@
// Shared types, constants and controller/datapath interface structs
// for the vertical column interpolator. No dependencies.
package vcli_pkg;

    localparam int MAX_LEVELS_DEF = 64;
    localparam int CFG_W          = 7;
    localparam int IDX_W          = 2;
    localparam int DIV_STEPS      = 32;

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_COORD_DESC = 2'd0;
    localparam logic [IDX_W-1:0] REG_ADD_BASE   = 2'd1;
    localparam logic [IDX_W-1:0] REG_NUM_LEVELS = 2'd2;

    localparam logic             COORD_DESC_RST = 1'b0;
    localparam logic             ADD_BASE_RST   = 1'b1;
    localparam logic [CFG_W-1:0] NUM_LEVELS_RST = 7'd64;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // bracket status codes
    localparam logic [1:0] ST_INTERIOR  = 2'd0;
    localparam logic [1:0] ST_BELOW     = 2'd1;
    localparam logic [1:0] ST_ABOVE     = 2'd2;
    localparam logic [1:0] ST_ZERO_SPAN = 2'd3;

    // value memory read address select
    localparam logic [1:0] VA_FIRST = 2'd0;
    localparam logic [1:0] VA_LAST  = 2'd1;
    localparam logic [1:0] VA_K     = 2'd2;
    localparam logic [1:0] VA_KM1   = 2'd3;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] coord;
        logic signed [31:0] sample_value;
        logic signed [31:0] target;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic [1:0]         bracket_status;
    } out_word_t;

    typedef struct packed {
        logic       load;
        logic       start;
        logic       scan_adv;
        logic       scan_stop;
        logic [1:0] vsel;
        logic       lat_hi;
        logic       div_step;
        logic       mul;
        logic       fin;
        logic       put;
        logic       use_interp;
        logic [1:0] code;
    } cmd_t;

    typedef struct packed {
        logic go;
        logic k_zero;
        logic k_last;
        logic den_zero;
        logic div_last;
    } sts_t;

endpackage

@@ design/vcli_ctrl.sv @@
// Sequencer for loads and queries: scan, fetch, divide, multiply, write-out.
// Depends on vcli_pkg.
module vcli_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_mode,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  vcli_pkg::sts_t  sts,
    output vcli_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_RD_END,
        S_END_DATA,
        S_RD_HI,
        S_RD_LO,
        S_DIV,
        S_MUL,
        S_FIN,
        S_PUT
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] code_reg, code_next;
    logic       out_valid_reg, out_valid_next;
    logic       interp_reg, interp_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        interp_next    = interp_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.code       = code_reg;
        cmd.use_interp = interp_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_mode == vcli_pkg::MODE_QUERY)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_SCAN:
            begin
                if (sts.go)
                begin
                    if (sts.k_last)
                    begin
                        code_next  = vcli_pkg::ST_ABOVE;
                        state_next = S_RD_END;
                    end
                    else
                    begin
                        cmd.scan_adv = 1'b1;
                    end
                end
                else
                begin
                    cmd.scan_stop = 1'b1;
                    if (sts.k_zero)
                    begin
                        code_next  = vcli_pkg::ST_BELOW;
                        state_next = S_RD_END;
                    end
                    else
                    begin
                        state_next = S_RD_HI;
                    end
                end
            end
            S_RD_END:
            begin
                cmd.vsel    = (code_reg == vcli_pkg::ST_BELOW) ? vcli_pkg::VA_FIRST
                                                               : vcli_pkg::VA_LAST;
                interp_next = 1'b0;
                state_next  = S_END_DATA;
            end
            S_END_DATA:
            begin
                cmd.lat_hi = 1'b1;
                state_next = S_PUT;
            end
            S_RD_HI:
            begin
                cmd.vsel   = vcli_pkg::VA_K;
                state_next = S_RD_LO;
            end
            S_RD_LO:
            begin
                cmd.vsel   = vcli_pkg::VA_KM1;
                cmd.lat_hi = 1'b1;
                if (sts.den_zero)
                begin
                    code_next   = vcli_pkg::ST_ZERO_SPAN;
                    interp_next = 1'b0;
                    state_next  = S_PUT;
                end
                else
                begin
                    code_next   = vcli_pkg::ST_INTERIOR;
                    interp_next = 1'b1;
                    state_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd.fin    = 1'b1;
                state_next = S_PUT;
            end
            S_PUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.put        = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            code_reg      <= vcli_pkg::ST_INTERIOR;
            out_valid_reg <= 1'b0;
            interp_reg    <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
            interp_reg    <= interp_next;
        end
    end

endmodule

@@ design/vcli_dp.sv @@
// Datapath: level stores, scan compare, serial divider, multiplier, output register.
// Depends on vcli_pkg.
module vcli_dp #(
    parameter int MAX_LEVELS = vcli_pkg::MAX_LEVELS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  vcli_pkg::in_word_t                in_data,
    input  logic                              coord_desc,
    input  logic                              add_base,
    input  logic [$clog2(MAX_LEVELS+1)-1:0]   nz,
    input  vcli_pkg::cmd_t                    cmd,
    output vcli_pkg::sts_t                    sts,
    output vcli_pkg::out_word_t               out_data
);

    localparam int NW = $clog2(MAX_LEVELS + 1);
    localparam int AW = $clog2(MAX_LEVELS);
    localparam int DCW = $clog2(vcli_pkg::DIV_STEPS);

    logic signed [31:0] coord_mem [MAX_LEVELS];
    logic signed [31:0] value_mem [MAX_LEVELS];
    logic signed [31:0] coord_rd_reg;
    logic signed [31:0] value_rd_reg;

    logic [NW-1:0]      load_count_reg, load_count_next;
    logic [NW-1:0]      wr_idx;
    logic signed [31:0] base_reg;
    logic signed [32:0] t_reg;
    logic [NW-1:0]      k_reg;
    logic signed [31:0] c_prev_reg;
    logic [32:0]        rem_reg;
    logic [31:0]        den_reg;
    logic [31:0]        s_reg;
    logic [DCW-1:0]     div_cnt_reg;
    logic signed [31:0] vhi_reg;
    logic signed [31:0] vlo_reg;
    logic [31:0]        mag_reg;
    logic               neg_reg;
    logic [63:0]        prod_reg;
    logic [32:0]        delta_reg;
    vcli_pkg::out_word_t out_reg;

    logic [NW-1:0]      nz_m1;
    logic [NW-1:0]      k_p1;
    logic [NW-1:0]      k_m1;
    logic [AW-1:0]      craddr;
    logic [AW-1:0]      vraddr;
    logic signed [32:0] c_ext;
    logic signed [33:0] num_diff;
    logic signed [32:0] den_diff;
    logic signed [32:0] dv;
    logic [33:0]        rem2;
    logic [64:0]        rounded;
    logic signed [34:0] res_wide;
    logic signed [31:0] res_sat;

    assign nz_m1  = nz - NW'(1);
    assign k_p1   = k_reg + NW'(1);
    assign k_m1   = k_reg - NW'(1);
    assign wr_idx = (load_count_reg >= nz) ? '0 : load_count_reg;
    assign load_count_next = wr_idx + NW'(1);

    assign craddr = cmd.scan_adv ? k_p1[AW-1:0] : '0;

    always_comb
    begin
        case (cmd.vsel)
            vcli_pkg::VA_FIRST: vraddr = '0;
            vcli_pkg::VA_LAST:  vraddr = nz_m1[AW-1:0];
            vcli_pkg::VA_K:     vraddr = k_reg[AW-1:0];
            vcli_pkg::VA_KM1:   vraddr = k_m1[AW-1:0];
            default:            vraddr = '0;
        endcase
    end

    // level stores, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            coord_mem[wr_idx[AW-1:0]] <= in_data.coord;
            value_mem[wr_idx[AW-1:0]] <= in_data.sample_value;
        end
        coord_rd_reg <= coord_mem[craddr];
        value_rd_reg <= value_mem[vraddr];
    end

    assign c_ext    = 33'(coord_rd_reg);
    assign num_diff = 34'(c_ext) - 34'(t_reg);
    assign den_diff = c_ext - 33'(c_prev_reg);
    assign dv       = 33'(vhi_reg) - 33'(vlo_reg);
    assign rem2     = {rem_reg, 1'b0};
    assign rounded  = 65'(prod_reg) + 65'(33'h080000000);

    assign sts.go       = coord_desc ? (t_reg < c_ext) : (t_reg > c_ext);
    assign sts.k_zero   = (k_reg == '0);
    assign sts.k_last   = (k_reg == nz_m1);
    assign sts.den_zero = (den_reg == '0);
    assign sts.div_last = (div_cnt_reg == DCW'(vcli_pkg::DIV_STEPS - 1));

    assign res_wide = neg_reg ? (35'(vhi_reg) + 35'($signed({2'b00, delta_reg})))
                              : (35'(vhi_reg) - 35'($signed({2'b00, delta_reg})));

    always_comb
    begin
        if (!cmd.use_interp)
            res_sat = vhi_reg;
        else if (res_wide > 35'sd2147483647)
            res_sat = 32'sh7FFFFFFF;
        else if (res_wide < -35'sd2147483648)
            res_sat = 32'sh80000000;
        else
            res_sat = res_wide[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            load_count_reg <= '0;
        else if (cmd.load)
            load_count_reg <= load_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && (wr_idx == '0))
            base_reg <= in_data.coord;
        if (cmd.start)
        begin
            t_reg <= add_base ? (33'(in_data.target) + 33'(base_reg)) : 33'(in_data.target);
            k_reg <= '0;
        end
        if (cmd.scan_adv)
        begin
            k_reg      <= k_p1;
            c_prev_reg <= coord_rd_reg;
        end
        if (cmd.scan_stop)
        begin
            rem_reg     <= num_diff[33] ? 33'(-num_diff) : num_diff[32:0];
            den_reg     <= den_diff[32] ? 32'(-den_diff) : den_diff[31:0];
            div_cnt_reg <= '0;
        end
        if (cmd.lat_hi)
            vhi_reg <= value_rd_reg;
        if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DCW'(1);
            if (rem2 >= 34'(den_reg))
            begin
                rem_reg <= 33'(rem2 - 34'(den_reg));
                s_reg   <= {s_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem2[32:0];
                s_reg   <= {s_reg[30:0], 1'b0};
            end
            if (div_cnt_reg == '0)
                vlo_reg <= value_rd_reg;
            else
            begin
                mag_reg <= dv[32] ? 32'(-dv) : dv[31:0];
                neg_reg <= dv[32];
            end
        end
        if (cmd.mul)
            prod_reg <= 64'(mag_reg) * 64'(s_reg);
        if (cmd.fin)
            delta_reg <= rounded[64:32];
        if (cmd.put)
        begin
            out_reg.result_value   <= res_sat;
            out_reg.bracket_status <= cmd.code;
        end
    end

    assign out_data = out_reg;

endmodule

@@ design/vertical_column_linear_interp.sv @@
// Query: the scan takes one cycle per level examined. An interior word then passes
// through 2 fetches, a 32-step divider, multiply, round and output; an end of column
// or zero span skips the divider, multiply and round. A load makes no word.
// One query in flight; input is taken again from the cycle after the word is registered,
// and a held word only stalls the next query's write-out. Reset clears control state
// and config to defaults; level stores are not cleared (no clearing pass).
module vertical_column_linear_interp #(
    parameter int MAX_LEVELS = vcli_pkg::MAX_LEVELS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  vcli_pkg::in_word_t               in_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output vcli_pkg::out_word_t              out_data,
    input  logic                             cfg_we,
    input  logic [vcli_pkg::IDX_W-1:0]       cfg_index,
    input  logic [vcli_pkg::CFG_W-1:0]       cfg_data
);

    localparam int NW = $clog2(MAX_LEVELS + 1);
    localparam int CW = (NW > vcli_pkg::CFG_W) ? NW : vcli_pkg::CFG_W;

    logic                       coord_desc_reg;
    logic                       add_base_reg;
    logic [vcli_pkg::CFG_W-1:0] num_levels_reg;
    logic [CW-1:0]              nl_ext;
    logic [CW-1:0]              nz_ext;
    logic [NW-1:0]              nz;
    logic                       in_fire;
    vcli_pkg::cmd_t             cmd;
    vcli_pkg::sts_t             sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coord_desc_reg <= vcli_pkg::COORD_DESC_RST;
            add_base_reg   <= vcli_pkg::ADD_BASE_RST;
            num_levels_reg <= vcli_pkg::NUM_LEVELS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vcli_pkg::REG_COORD_DESC: coord_desc_reg <= cfg_data[0];
                vcli_pkg::REG_ADD_BASE:   add_base_reg   <= cfg_data[0];
                vcli_pkg::REG_NUM_LEVELS: num_levels_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // clamp level count to 1..MAX_LEVELS
    assign nl_ext = CW'(num_levels_reg);
    always_comb
    begin
        if (nl_ext == '0)
            nz_ext = CW'(1);
        else if (nl_ext > CW'(MAX_LEVELS))
            nz_ext = CW'(MAX_LEVELS);
        else
            nz_ext = nl_ext;
    end
    assign nz = nz_ext[NW-1:0];

    assign in_fire = in_valid && in_ready;

    vcli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_mode   (in_data.mode),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    vcli_dp #(
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_data    (in_data),
        .coord_desc (coord_desc_reg),
        .add_base   (add_base_reg),
        .nz         (nz),
        .cmd        (cmd),
        .sts        (sts),
        .out_data   (out_data)
    );

    // a query blocks further input until its word is written out
    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.mode == vcli_pkg::MODE_QUERY) |=> !in_ready)
        else $error("input taken during query");

    // a new word appears only after a query was in flight
    a_word_from_query: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result word without query");

    // loads never make a word
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_data.mode == vcli_pkg::MODE_LOAD && !out_valid) |=> !out_valid)
        else $error("load produced a word");

endmodule
